@@ rtl/core/pgv_pkg.sv @@
// ----------------------------------------------------------------------------
// pgv_pkg
// Shared types and constants for the pairwise gravity velocity update block.
// ----------------------------------------------------------------------------
package pgv_pkg;

   typedef struct packed {
      logic signed [31:0] src_x;
      logic signed [31:0] src_y;
      logic [31:0]        src_mass;
      logic [30:0]        src_radius;
      logic signed [31:0] tgt_x;
      logic signed [31:0] tgt_y;
      logic signed [31:0] tgt_vx;
      logic signed [31:0] tgt_vy;
      logic [30:0]        tgt_radius;
   } req_type;

   typedef struct packed {
      logic signed [31:0] new_vx;
      logic signed [31:0] new_vy;
      logic               touching;
      logic               saturated;
   } rsp_type;

   // Per-pair values that ride alongside the arithmetic units.
   typedef struct packed {
      logic [31:0] vx;
      logic [31:0] vy;
      logic        neg_x;
      logic        neg_y;
      logic        touching;
      logic        zero;
      logic [32:0] adx;
      logic [32:0] ady;
   } side_type;

   localparam int SIDE_W  = $bits(side_type);
   localparam int AXIS_W  = 33;
   localparam int D2_W    = 66;
   localparam int DIST_W  = 33;
   localparam int GM_W    = 63;
   localparam int REG_W   = 31;
   localparam int DV_EXP  = 33;
   localparam int DV_W    = DV_EXP + 1;

   localparam logic [REG_W-1:0] TIME_STEP_RESET  = 31'd1092;
   localparam logic [REG_W-1:0] GRAV_CONST_RESET = 31'd65536;

   localparam logic REG_TIME_STEP  = 1'b0;
   localparam logic REG_GRAV_CONST = 1'b1;

   localparam logic [31:0] VEL_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] VEL_MIN = 32'h8000_0000;

endpackage

@@ rtl/core/pgv_div.sv @@
// ----------------------------------------------------------------------------
// pgv_div
// Pipelined restoring divider, one quotient bit per stage, shared divisor.
// ----------------------------------------------------------------------------
module pgv_div #(
   parameter int NW = 8,
   parameter int DW = 8,
   parameter int NL = 1,
   parameter int SW = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [NL-1:0][NW-1:0] in_num,
   input  logic [NL-1:0][DW-1:0] in_rem,
   input  logic [DW-1:0]         in_den,
   input  logic [SW-1:0]         in_side,
   output logic                  out_valid,
   output logic [NL-1:0][NW-1:0] out_quo,
   output logic [SW-1:0]         out_side
);
   logic                  valid_ff [NW];
   logic [NL-1:0][NW-1:0] num_ff   [NW];
   logic [NL-1:0][NW-1:0] num_in   [NW];
   logic [NL-1:0][DW-1:0] rem_ff   [NW];
   logic [NL-1:0][DW-1:0] rem_in   [NW];
   logic [DW-1:0]         den_ff   [NW];
   logic [SW-1:0]         side_ff  [NW];

   for (genvar s = 0; s < NW; s++) begin : g_stage
      logic                  valid_src;
      logic [NL-1:0][NW-1:0] num_src;
      logic [NL-1:0][DW-1:0] rem_src;
      logic [DW-1:0]         den_src;
      logic [SW-1:0]         side_src;

      if (s == 0) begin : g_first
         assign valid_src = in_valid;
         assign num_src   = in_num;
         assign rem_src   = in_rem;
         assign den_src   = in_den;
         assign side_src  = in_side;
      end else begin : g_next
         assign valid_src = valid_ff[s-1];
         assign num_src   = num_ff[s-1];
         assign rem_src   = rem_ff[s-1];
         assign den_src   = den_ff[s-1];
         assign side_src  = side_ff[s-1];
      end

      // The dividend shifts out at the top while quotient bits shift in below.
      for (genvar l = 0; l < NL; l++) begin : g_lane
         logic [DW:0] trial;
         logic        fits;
         assign trial = {rem_src[l], num_src[l][NW-1]};
         assign fits  = (trial >= {1'b0, den_src});
         assign rem_in[s][l] = fits ? DW'(trial - {1'b0, den_src}) : trial[DW-1:0];
         assign num_in[s][l] = {num_src[l][NW-2:0], fits};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            num_ff[s]  <= num_in[s];
            rem_ff[s]  <= rem_in[s];
            den_ff[s]  <= den_src;
            side_ff[s] <= side_src;
         end
      end
   end

   assign out_valid = valid_ff[NW-1];
   assign out_quo   = num_ff[NW-1];
   assign out_side  = side_ff[NW-1];

endmodule

@@ rtl/core/pgv_sqrt.sv @@
// ----------------------------------------------------------------------------
// pgv_sqrt
// Pipelined digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module pgv_sqrt #(
   parameter int VW = 8,
   parameter int SW = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [VW-1:0]     in_val,
   input  logic [SW-1:0]     in_side,
   output logic              out_valid,
   output logic [VW/2-1:0]   out_root,
   output logic [SW-1:0]     out_side
);
   localparam int RW  = VW / 2;
   localparam int RMW = RW + 2;

   logic           valid_ff [RW];
   logic [VW-1:0]  val_ff   [RW];
   logic [VW-1:0]  val_in   [RW];
   logic [RW-1:0]  root_ff  [RW];
   logic [RW-1:0]  root_in  [RW];
   logic [RMW-1:0] rem_ff   [RW];
   logic [RMW-1:0] rem_in   [RW];
   logic [SW-1:0]  side_ff  [RW];

   for (genvar s = 0; s < RW; s++) begin : g_stage
      logic           valid_src;
      logic [VW-1:0]  val_src;
      logic [RW-1:0]  root_src;
      logic [RMW-1:0] rem_src;
      logic [SW-1:0]  side_src;
      logic [RMW+1:0] trial_rem;
      logic [RMW-1:0] trial;
      logic           fits;

      if (s == 0) begin : g_first
         assign valid_src = in_valid;
         assign val_src   = in_val;
         assign root_src  = '0;
         assign rem_src   = '0;
         assign side_src  = in_side;
      end else begin : g_next
         assign valid_src = valid_ff[s-1];
         assign val_src   = val_ff[s-1];
         assign root_src  = root_ff[s-1];
         assign rem_src   = rem_ff[s-1];
         assign side_src  = side_ff[s-1];
      end

      // Bring down the next pair of radicand bits and try root*4+1.
      assign trial_rem = {rem_src, val_src[VW-1 -: 2]};
      assign trial     = {root_src, 2'b01};
      assign fits      = (trial_rem >= {2'b00, trial});
      assign rem_in[s] = fits ? RMW'(trial_rem - {2'b00, trial}) : trial_rem[RMW-1:0];
      assign root_in[s] = {root_src[RW-2:0], fits};
      assign val_in[s]  = {val_src[VW-3:0], 2'b00};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            val_ff[s]  <= val_in[s];
            root_ff[s] <= root_in[s];
            rem_ff[s]  <= rem_in[s];
            side_ff[s] <= side_src;
         end
      end
   end

   assign out_valid = valid_ff[RW-1];
   assign out_root  = root_ff[RW-1];
   assign out_side  = side_ff[RW-1];

endmodule

@@ rtl/core/pgv_mul.sv @@
// ----------------------------------------------------------------------------
// pgv_mul
// Pipelined wide multiplier: one 32-bit slice of the wide operand per stage.
// ----------------------------------------------------------------------------
module pgv_mul #(
   parameter int AW = 32,
   parameter int BW = 32,
   parameter int NL = 1,
   parameter int SW = 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic [NL-1:0][AW-1:0]    in_a,
   input  logic [NL-1:0][BW-1:0]    in_b,
   input  logic [SW-1:0]            in_side,
   output logic                     out_valid,
   output logic [NL-1:0][AW+BW-1:0] out_prod,
   output logic [SW-1:0]            out_side
);
   localparam int PW  = AW + BW;
   localparam int NC  = (AW + 31) / 32;
   localparam int APW = NC * 32;

   logic                  valid_ff [NC];
   logic [NL-1:0][AW-1:0] a_ff     [NC];
   logic [NL-1:0][BW-1:0] b_ff     [NC];
   logic [NL-1:0][PW-1:0] acc_ff   [NC];
   logic [NL-1:0][PW-1:0] acc_in   [NC];
   logic [SW-1:0]         side_ff  [NC];

   for (genvar c = 0; c < NC; c++) begin : g_stage
      logic                  valid_src;
      logic [NL-1:0][AW-1:0] a_src;
      logic [NL-1:0][BW-1:0] b_src;
      logic [NL-1:0][PW-1:0] acc_src;
      logic [SW-1:0]         side_src;

      if (c == 0) begin : g_first
         assign valid_src = in_valid;
         assign a_src     = in_a;
         assign b_src     = in_b;
         assign acc_src   = '0;
         assign side_src  = in_side;
      end else begin : g_next
         assign valid_src = valid_ff[c-1];
         assign a_src     = a_ff[c-1];
         assign b_src     = b_ff[c-1];
         assign acc_src   = acc_ff[c-1];
         assign side_src  = side_ff[c-1];
      end

      for (genvar l = 0; l < NL; l++) begin : g_lane
         logic [APW-1:0]  a_pad;
         logic [31+BW:0]  part;
         assign a_pad = APW'(a_src[l]);
         assign part  = a_pad[32*c +: 32] * b_src[l];
         assign acc_in[c][l] = acc_src[l] + (PW'(part) << (32 * c));
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[c] <= 1'b0;
         end else if (en) begin
            valid_ff[c] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            a_ff[c]    <= a_src;
            b_ff[c]    <= b_src;
            acc_ff[c]  <= acc_in[c];
            side_ff[c] <= side_src;
         end
      end
   end

   assign out_valid = valid_ff[NC-1];
   assign out_prod  = acc_ff[NC-1];
   assign out_side  = side_ff[NC-1];

endmodule

@@ rtl/core/pairwise_gravity_velocity_update.sv @@
// ----------------------------------------------------------------------------
// pairwise_gravity_velocity_update
// 2D Newtonian pull of a source body on a target body's velocity, Q16.16.
// ----------------------------------------------------------------------------
// Pipeline: most stages lie in the two bit-per-stage dividers and the square
//          root pipeline.
// Throughput: one pair per cycle; every stage advances together whenever the
//          output register is empty or its transfer completes.
// Reset: synchronous; clears all valid bits and loads the register defaults.
module pairwise_gravity_velocity_update #(
   parameter int FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pgv_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pgv_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import pgv_pkg::*;

   localparam int ACC_W = GM_W + 2 * FRAC_BITS;
   localparam int X_W   = ACC_W + AXIS_W;
   localparam int K     = DV_EXP + FRAC_BITS;
   localparam int HI_W  = X_W - K;
   localparam int AX_W  = K + 1;
   localparam int P_W   = AX_W + REG_W;
   localparam int DF_W  = P_W - FRAC_BITS;
   localparam logic [AX_W-1:0] AX_CAP = {1'b1, {K{1'b0}}};
   localparam logic [DF_W-1:0] DV_CAP = DF_W'({1'b1, {DV_EXP{1'b0}}});

   // Configuration registers.
   logic [REG_W-1:0] time_step_ff;
   logic [REG_W-1:0] grav_const_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff  <= TIME_STEP_RESET;
         grav_const_ff <= GRAV_CONST_RESET;
      end else if (psel && penable && pwrite) begin
         case (paddr[2])
            REG_TIME_STEP:  time_step_ff  <= pwdata[REG_W-1:0];
            REG_GRAV_CONST: grav_const_ff <= pwdata[REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_TIME_STEP:  prdata = {1'b0, time_step_ff};
         REG_GRAV_CONST: prdata = {1'b0, grav_const_ff};
         default:        prdata = '0;
      endcase
   end

   assign pready = 1'b1;

   // All stages move in lock step while the output register can take a result.
   logic    adv;
   logic    out_valid_ff;
   rsp_type out_ff;

   assign adv       = !out_valid_ff || rsp_ready;
   assign req_ready = adv;

   // Stage 1: coordinate differences and radius sum.
   logic            s1_valid_ff;
   side_type        s1_side_ff, s1_side_in;
   logic [31:0]     s1_rsum_ff, s1_rsum_in;
   logic [31:0]     s1_mass_ff;
   logic [AXIS_W-1:0] dx_in, dy_in;

   always_comb begin
      dx_in = {req_data.src_x[31], req_data.src_x} - {req_data.tgt_x[31], req_data.tgt_x};
      dy_in = {req_data.src_y[31], req_data.src_y} - {req_data.tgt_y[31], req_data.tgt_y};
      s1_side_in          = '0;
      s1_side_in.vx       = req_data.tgt_vx;
      s1_side_in.vy       = req_data.tgt_vy;
      s1_side_in.neg_x    = dx_in[AXIS_W-1];
      s1_side_in.neg_y    = dy_in[AXIS_W-1];
      s1_side_in.adx      = dx_in[AXIS_W-1] ? (~dx_in + 1'b1) : dx_in;
      s1_side_in.ady      = dy_in[AXIS_W-1] ? (~dy_in + 1'b1) : dy_in;
      s1_rsum_in = 32'(req_data.src_radius) + 32'(req_data.tgt_radius);
   end

   // Stage 2: squares and the G*m product.
   logic              s2_valid_ff;
   side_type          s2_side_ff;
   logic [D2_W-1:0]   s2_sqx_ff, s2_sqx_in, s2_sqy_ff, s2_sqy_in;
   logic [63:0]       s2_rsq_ff, s2_rsq_in;
   logic [GM_W-1:0]   s2_gm_ff, s2_gm_in;

   assign s2_sqx_in = s1_side_ff.adx * s1_side_ff.adx;
   assign s2_sqy_in = s1_side_ff.ady * s1_side_ff.ady;
   assign s2_rsq_in = s1_rsum_ff * s1_rsum_ff;
   assign s2_gm_in  = grav_const_ff * s1_mass_ff;

   // Stage 3: squared distance, contact test and coincidence.
   logic            s3_valid_ff;
   side_type        s3_side_ff, s3_side_in;
   logic [D2_W-1:0] s3_d2_ff, s3_d2_in;
   logic [GM_W-1:0] s3_gm_ff;

   always_comb begin
      s3_d2_in            = s2_sqx_ff + s2_sqy_ff;
      s3_side_in          = s2_side_ff;
      s3_side_in.touching = (s3_d2_in <= {2'b00, s2_rsq_ff});
      s3_side_in.zero     = (s3_d2_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_side_ff <= s1_side_in;
         s1_rsum_ff <= s1_rsum_in;
         s1_mass_ff <= req_data.src_mass;
         s2_side_ff <= s1_side_ff;
         s2_sqx_ff  <= s2_sqx_in;
         s2_sqy_ff  <= s2_sqy_in;
         s2_rsq_ff  <= s2_rsq_in;
         s2_gm_ff   <= s2_gm_in;
         s3_side_ff <= s3_side_in;
         s3_d2_ff   <= s3_d2_in;
         s3_gm_ff   <= s2_gm_ff;
      end
   end

   // Acceleration magnitude: G*m*2^(2F) / d2.
   logic                     da_valid;
   logic [0:0][ACC_W-1:0]    da_quo;
   logic [SIDE_W+D2_W-1:0]   da_side;

   pgv_div #(.NW(ACC_W), .DW(D2_W), .NL(1), .SW(SIDE_W + D2_W)) u_div_accel (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_valid (s3_valid_ff),
      .in_num   ({s3_gm_ff, {(2 * FRAC_BITS){1'b0}}}),
      .in_rem   ('0),
      .in_den   (s3_d2_ff),
      .in_side  ({s3_side_ff, s3_d2_ff}),
      .out_valid(da_valid),
      .out_quo  (da_quo),
      .out_side (da_side)
   );

   // Distance: floor of the square root of d2.
   logic                    sq_valid;
   logic [DIST_W-1:0]       sq_root;
   logic [SIDE_W+ACC_W-1:0] sq_side;

   pgv_sqrt #(.VW(D2_W), .SW(SIDE_W + ACC_W)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_valid (da_valid),
      .in_val   (da_side[D2_W-1:0]),
      .in_side  ({da_side[SIDE_W+D2_W-1:D2_W], da_quo[0]}),
      .out_valid(sq_valid),
      .out_root (sq_root),
      .out_side (sq_side)
   );

   side_type sq_side_s;
   assign sq_side_s = side_type'(sq_side[SIDE_W+ACC_W-1:ACC_W]);

   // a * |d| per axis; lane 0 is x, lane 1 is y.
   logic                      m1_valid;
   logic [1:0][X_W-1:0]       m1_prod;
   logic [SIDE_W+DIST_W-1:0]  m1_side;

   pgv_mul #(.AW(ACC_W), .BW(AXIS_W), .NL(2), .SW(SIDE_W + DIST_W)) u_mul_axis (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_valid (sq_valid),
      .in_a     ({sq_side[ACC_W-1:0], sq_side[ACC_W-1:0]}),
      .in_b     ({sq_side_s.ady, sq_side_s.adx}),
      .in_side  ({sq_side_s, sq_root}),
      .out_valid(m1_valid),
      .out_prod (m1_prod),
      .out_side (m1_side)
   );

   // Stage 4: split the products for the divide by distance and flag any
   // quotient that would reach the clamp value.
   logic                    s4_valid_ff;
   side_type                s4_side_ff;
   logic [DIST_W-1:0]       s4_dist_ff;
   logic [1:0]              s4_ovf_ff, s4_ovf_in;
   logic [1:0][K-1:0]       s4_num_ff, s4_num_in;
   logic [1:0][DIST_W-1:0]  s4_rem_ff, s4_rem_in;

   for (genvar l = 0; l < 2; l++) begin : g_split
      assign s4_ovf_in[l] = (m1_prod[l][X_W-1:K] >= HI_W'(m1_side[DIST_W-1:0]));
      assign s4_num_in[l] = m1_prod[l][K-1:0];
      assign s4_rem_in[l] = m1_prod[l][K+DIST_W-1:K];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s4_valid_ff <= m1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_side_ff <= side_type'(m1_side[SIDE_W+DIST_W-1:DIST_W]);
         s4_dist_ff <= m1_side[DIST_W-1:0];
         s4_ovf_ff  <= s4_ovf_in;
         s4_num_ff  <= s4_num_in;
         s4_rem_ff  <= s4_rem_in;
      end
   end

   // Per-axis acceleration: a * |d| / dist.
   logic                 dx_valid;
   logic [1:0][K-1:0]    dx_quo;
   logic [SIDE_W+1:0]    dx_side;

   pgv_div #(.NW(K), .DW(DIST_W), .NL(2), .SW(SIDE_W + 2)) u_div_axis (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_valid (s4_valid_ff),
      .in_num   (s4_num_ff),
      .in_rem   (s4_rem_ff),
      .in_den   (s4_dist_ff),
      .in_side  ({s4_side_ff, s4_ovf_ff}),
      .out_valid(dx_valid),
      .out_quo  (dx_quo),
      .out_side (dx_side)
   );

   logic [1:0][AX_W-1:0] ax;

   for (genvar l = 0; l < 2; l++) begin : g_clamp
      assign ax[l] = dx_side[l] ? AX_CAP : {1'b0, dx_quo[l]};
   end

   // Acceleration times time step.
   logic               m2_valid;
   logic [1:0][P_W-1:0] m2_prod;
   logic [SIDE_W-1:0]  m2_side;

   pgv_mul #(.AW(AX_W), .BW(REG_W), .NL(2), .SW(SIDE_W)) u_mul_step (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_valid (dx_valid),
      .in_a     (ax),
      .in_b     ({time_step_ff, time_step_ff}),
      .in_side  (dx_side[SIDE_W+1:2]),
      .out_valid(m2_valid),
      .out_prod (m2_prod),
      .out_side (m2_side)
   );

   // Output stage: scale, apply toward the source and saturate; coincident bodies keep their velocity.
   side_type             fin_side;
   logic [1:0][31:0]     vel;
   logic [1:0]           neg;
   logic [1:0][31:0]     vel_out;
   logic [1:0]           clip;
   rsp_type              out_in;

   assign fin_side = side_type'(m2_side);
   assign vel      = {fin_side.vy, fin_side.vx};
   assign neg      = {fin_side.neg_y, fin_side.neg_x};

   for (genvar l = 0; l < 2; l++) begin : g_apply
      logic [DF_W-1:0] dv_full;
      logic [DV_W-1:0] dv;
      logic [DV_W+1:0] sum;
      logic            over;
      logic            under;

      assign dv_full = m2_prod[l][P_W-1:FRAC_BITS];
      assign dv      = (dv_full > DV_CAP) ? DV_CAP[DV_W-1:0] : dv_full[DV_W-1:0];
      assign sum     = neg[l] ? ({{4{vel[l][31]}}, vel[l]} - {2'b00, dv})
                              : ({{4{vel[l][31]}}, vel[l]} + {2'b00, dv});
      assign over    = !sum[DV_W+1] && (sum[DV_W:31] != '0);
      assign under   = sum[DV_W+1] && (sum[DV_W:31] != '1);
      assign vel_out[l] = over ? VEL_MAX : (under ? VEL_MIN : sum[31:0]);
      assign clip[l]    = over || under;
   end

   always_comb begin
      out_in.touching = fin_side.touching;
      if (fin_side.zero) begin
         out_in.new_vx    = fin_side.vx;
         out_in.new_vy    = fin_side.vy;
         out_in.saturated = 1'b0;
      end else begin
         out_in.new_vx    = vel_out[0];
         out_in.new_vy    = vel_out[1];
         out_in.saturated = |clip;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= m2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule
